FILE: hdl/evd_pkg.sv
// ----------------------------------------------------------------------------
// evd_pkg - shared types for the exact vertex deduplicator
// Payload structs for both channels and the command/status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package evd_pkg;

    // Width of one vertex word and of a full stored vertex
    localparam int WORD_W   = 32;
    localparam int VERTEX_W = 8 * WORD_W;

    // One incoming vertex transaction
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] norm_x;
        logic [31:0] norm_y;
        logic [31:0] norm_z;
        logic [31:0] tex_s;
        logic [31:0] tex_t;
        logic        last_in_mesh;
    } vertex_t;

    // One outgoing result transaction
    typedef struct packed {
        logic [7:0] vertex_index;
        logic       is_new;
        logic       overflow;
        logic [8:0] unique_count;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // latch the accepted vertex, restart the scan
        logic search;  // scan one table entry
        logic commit;  // form the result, update the table and count
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;     // scan found an equal entry
        logic miss;    // scan covered every entry without a match
    } dp_status_t;

endpackage

FILE: hdl/evd_ram.sv
// ----------------------------------------------------------------------------
// evd_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module evd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/evd_ctrl.sv
// ----------------------------------------------------------------------------
// evd_ctrl - sequencer for the deduplicator
// Accepts one vertex, steps the datapath through the table scan, then
// commits the result into the output register when it is free.
// ----------------------------------------------------------------------------
module evd_ctrl
    import evd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vtx_valid,
    output logic       vtx_ready,
    output logic       res_valid,
    input  logic       res_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       slot_free;

    assign slot_free = !res_valid_reg || res_ready;
    assign vtx_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (vtx_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (status.hit || status.miss)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on commit, drop when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // A commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!res_valid_reg || res_ready))
        else $error("result overwritten before it was taken");

    // A scan ends in exactly one way
    a_hit_miss_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.hit && status.miss))
        else $error("scan reports hit and miss together");

    // After a load the scan starts in the following cycle
    a_load_then_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.search)
        else $error("scan did not start after load");

endmodule

FILE: hdl/evd_datapath.sv
// ----------------------------------------------------------------------------
// evd_datapath - vertex table, scan pipeline and result register
// Holds the accepted vertex, reads one table entry per cycle and compares
// all eight words, appends on a miss while the table has room and keeps the entry count.
// ----------------------------------------------------------------------------
module evd_datapath
    import evd_pkg::*;
#(
    parameter int MAX_UNIQUE = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  vertex_t    vtx_data,
    output result_t    res_data,
    input  dp_cmd_t    cmd,
    output dp_status_t status
);

    localparam int AW = $clog2(MAX_UNIQUE);
    localparam int CW = $clog2(MAX_UNIQUE + 1);

    vertex_t              item_reg;
    logic [VERTEX_W-1:0]  item_words;
    logic [VERTEX_W-1:0]  rdata;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        held_count;
    logic [CW-1:0]        last_idx;
    logic [CW-1:0]        rd_ptr_reg;
    logic [AW-1:0]        cmp_idx_reg;
    logic                 cmp_valid_reg;
    logic                 found_reg;
    logic [AW-1:0]        hit_idx_reg;
    result_t              res_reg;
    result_t              res_next;
    logic                 issue;
    logic                 match;
    logic                 count_zero;
    logic                 full;
    logic                 store;
    logic [AW-1:0]        out_idx;
    logic [31:0]          idx_wide;
    logic [31:0]          cnt_wide;

    assign item_words = {item_reg.pos_x, item_reg.pos_y, item_reg.pos_z,
                         item_reg.norm_x, item_reg.norm_y, item_reg.norm_z,
                         item_reg.tex_s, item_reg.tex_t};

    // Scan control
    assign issue      = cmd.search && (rd_ptr_reg < count_reg);
    assign count_zero = (count_reg == '0);
    assign last_idx   = count_reg - CW'(1);
    assign match      = (rdata == item_words);
    assign status.hit  = cmd.search && cmp_valid_reg && match;
    assign status.miss = cmd.search && (count_zero ||
                         (cmp_valid_reg && !match && CW'(cmp_idx_reg) == last_idx));

    evd_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (MAX_UNIQUE)
    ) u_table (
        .clk   (clk),
        .we    (store),
        .waddr (count_reg[AW-1:0]),
        .wdata (item_words),
        .re    (issue),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (rdata)
    );

    // Latch the accepted vertex
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= vtx_data;
        end
    end

    // Advance the read pointer and track which entry the RAM returns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.search)
        begin
            rd_ptr_reg    <= issue ? rd_ptr_reg + CW'(1) : rd_ptr_reg;
            cmp_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            cmp_idx_reg <= rd_ptr_reg[AW-1:0];
        end
        if (status.hit || status.miss)
        begin
            found_reg   <= status.hit;
            hit_idx_reg <= cmp_idx_reg;
        end
    end

    // Form the result and the new count
    assign full  = (count_reg == CW'(MAX_UNIQUE));
    assign store = cmd.commit && !found_reg && !full;

    always_comb
    begin
        held_count = count_reg;
        out_idx    = '0;
        if (found_reg)
        begin
            out_idx = hit_idx_reg;
        end
        else if (!full)
        begin
            out_idx    = count_reg[AW-1:0];
            held_count = count_reg + CW'(1);
        end
        idx_wide = 32'(out_idx);
        cnt_wide = 32'(held_count);
        res_next.vertex_index = idx_wide[7:0];
        res_next.is_new       = !found_reg && !full;
        res_next.overflow     = !found_reg && full;
        res_next.unique_count = cnt_wide[8:0];
        count_next = item_reg.last_in_mesh ? '0 : held_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_data = res_reg;

    // Entry count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_UNIQUE))
        else $error("entry count beyond table depth");

    // An append that does not end the mesh grows the count by one
    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (store && !item_reg.last_in_mesh) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("append did not advance entry count");

    // A compare only ever looks at a written entry
    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.search && cmp_valid_reg) |-> (CW'(cmp_idx_reg) < count_reg))
        else $error("compare on entry beyond count");

endmodule

FILE: hdl/exact_vertex_deduplicator.sv
// ----------------------------------------------------------------------------
// exact_vertex_deduplicator - vertex welding by exact bit match
// Returns the table index of each vertex, appending unseen vertices.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   vertex   | vtx_valid / vtx_ready     | vtx_data (vertex_t), in
//   result   | res_valid / res_ready     | res_data (result_t), out
//
// The table sits in one RAM with one read port, so the scan compares one
// entry per cycle against the registered read data before the result is
// committed. A match ends the scan early.
// Reset clears the entry count and the handshakes; table contents need no
// clearing since only entries below the count are read.
// A stalled result holds the commit, and with it the next vertex's result;
// the next vertex is taken as soon as the previous one is committed.
// ----------------------------------------------------------------------------
module exact_vertex_deduplicator
    import evd_pkg::*;
#(
    parameter int MAX_UNIQUE = 256
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    vtx_valid,
    output logic    vtx_ready,
    input  vertex_t vtx_data,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    evd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd),
        .status    (status)
    );

    evd_datapath #(
        .MAX_UNIQUE (MAX_UNIQUE)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .vtx_data (vtx_data),
        .res_data (res_data),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

FILE: dv/tb_exact_vertex_deduplicator.sv
// ----------------------------------------------------------------------------
// tb_exact_vertex_deduplicator - self-checking bench for exact vertex welding
// Sends meshes of raw-bit vertices over the vertex channel and predicts the
// index, the new and overflow flags and the entry count of every transaction.
// Results are checked in order while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_exact_vertex_deduplicator;
    import evd_pkg::*;

    localparam int TABLE_DEPTH     = 256;
    localparam int LIMIT_CYCLES    = 2_000_000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int PHASE_ITEMS     = 400;

    typedef logic [VERTEX_W-1:0] vertex_key_t;

    // Welding table mirror and in-order queue of predicted results
    class weld_scoreboard;
        vertex_key_t stored_keys[TABLE_DEPTH];
        int          held;
        result_t     pending_results[$];
        int          errors;
        int          checked;
        int          vertices;
        int          appended;
        int          matched;
        int          overflowed;
        int          meshes;

        function new();
            held       = 0;
            errors     = 0;
            checked    = 0;
            vertices   = 0;
            appended   = 0;
            matched    = 0;
            overflowed = 0;
            meshes     = 0;
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("ERROR result %0d: %s", checked, what);
        endtask

        // Search the held entries; append on a miss, flag overflow when full
        function void note_vertex(vertex_t v);
            vertex_key_t key;
            result_t     res;
            int          idx;
            bit          found;
            key   = {v.pos_x, v.pos_y, v.pos_z, v.norm_x, v.norm_y, v.norm_z,
                     v.tex_s, v.tex_t};
            res   = '0;
            idx   = 0;
            found = 1'b0;
            for (int k = 0; k < held; k++) begin
                if (stored_keys[k] == key) begin
                    idx   = k;
                    found = 1'b1;
                    break;
                end
            end
            if (found) begin
                matched++;
            end
            else if (held < TABLE_DEPTH) begin
                idx              = held;
                stored_keys[idx] = key;
                held++;
                res.is_new = 1'b1;
                appended++;
            end
            else begin
                res.overflow = 1'b1;
                overflowed++;
            end
            res.vertex_index = idx[7:0];
            res.unique_count = held[8:0];
            pending_results.push_back(res);
            vertices++;
            // empty the table after the last vertex of a mesh
            if (v.last_in_mesh) begin
                held = 0;
                meshes++;
            end
        endfunction

        // Compare one result transaction against the oldest prediction
        task check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.vertex_index !== want.vertex_index)
                report_mismatch($sformatf("vertex_index %0d, want %0d",
                                          got.vertex_index, want.vertex_index));
            if (got.is_new !== want.is_new)
                report_mismatch($sformatf("is_new %b, want %b", got.is_new, want.is_new));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("overflow %b, want %b",
                                          got.overflow, want.overflow));
            if (got.unique_count !== want.unique_count)
                report_mismatch($sformatf("unique_count %0d, want %0d",
                                          got.unique_count, want.unique_count));
            checked++;
        endtask
    endclass

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    vtx_valid = 1'b0;
    vertex_t vtx_data  = '0;
    logic    res_ready = 1'b0;
    logic    vtx_ready;
    logic    res_valid;
    result_t res_data;

    int send_idle_pct = 27;
    int recv_idle_pct = 80;
    int hold_cycles   = 0;
    int cycle_count   = 0;
    int items_sent    = 0;

    vertex_t        mesh_pool[$];
    weld_scoreboard sb = new();

    exact_vertex_deduplicator #(
        .MAX_UNIQUE (TABLE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx_data  (vtx_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Check accepted results, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res_data);
        if (hold_cycles > 0) begin
            res_ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else begin
            res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Mostly random words, with signed zero, NaN and the all-zero/all-one extremes
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FC0_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic vertex_t fresh_vertex();
        vertex_t v;
        v.pos_x        = random_word();
        v.pos_y        = random_word();
        v.pos_z        = random_word();
        v.norm_x       = random_word();
        v.norm_y       = random_word();
        v.norm_z       = random_word();
        v.tex_s        = random_word();
        v.tex_t        = random_word();
        v.last_in_mesh = 1'b0;
        return v;
    endfunction

    // Flip one data bit so the vertex differs from its source by a single bit
    function automatic vertex_t near_miss(vertex_t v);
        int pos;
        pos        = $urandom_range(1, VERTEX_W);
        v[pos]     = ~v[pos];
        return v;
    endfunction

    // Offer one vertex transaction after a random gap and hold it until taken
    task automatic send_vertex(vertex_t v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            vtx_valid <= 1'b0;
            @(posedge clk);
        end
        vtx_valid <= 1'b1;
        vtx_data  <= v;
        @(posedge clk);
        while (!vtx_ready)
            @(posedge clk);
        sb.note_vertex(v);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One mesh: repeats, single-bit near misses and fresh vertices
    task automatic run_mesh(int len, int dup_pct, bit end_fresh);
        vertex_t v;
        int      roll;
        mesh_pool.delete();
        for (int i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (mesh_pool.size() != 0 && roll < dup_pct && !(end_fresh && i == len - 1)) begin
                v = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
            end
            else if (mesh_pool.size() != 0 && roll < dup_pct + 10) begin
                v = near_miss(mesh_pool[$urandom_range(0, mesh_pool.size() - 1)]);
                mesh_pool.push_back(v);
            end
            else begin
                v = fresh_vertex();
                mesh_pool.push_back(v);
            end
            v.last_in_mesh = (i == len - 1);
            send_vertex(v);
        end
    endtask

    // A big mesh runs the table past full so it overflows, the rest are short
    task automatic run_phase(int s_pct, int r_pct, bit with_big_mesh);
        int target;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target        = items_sent + PHASE_ITEMS;
        if (with_big_mesh)
            run_mesh(TABLE_DEPTH + 64, 10, 1'b1);
        while (items_sent < target)
            run_mesh($urandom_range(1, 40), $urandom_range(0, 60), 1'b0);
    endtask

    // Directed corner vertices
    task automatic run_directed();
        vertex_t v;
        v = '0;
        send_vertex(v);
        v = '1;
        v.last_in_mesh = 1'b0;
        send_vertex(v);
        v = '0;
        send_vertex(v);
        // negative zero must not weld with positive zero
        v = '0;
        v.pos_x = 32'h8000_0000;
        send_vertex(v);
        v = '1;
        v.tex_t[0]     = 1'b0;
        v.last_in_mesh = 1'b0;
        send_vertex(v);
        // hit on the last vertex, then the table must be empty again
        v = '1;
        send_vertex(v);
        v.last_in_mesh = 1'b0;
        send_vertex(v);
        v = {{8{32'h7FC0_0000}}, 1'b1};
        send_vertex(v);
        // walk an all-ones word across the eight fields
        for (int w = 0; w < 8; w++) begin
            v = '0;
            v[VERTEX_W - w * WORD_W -: WORD_W] = '1;
            send_vertex(v);
        end
        v.last_in_mesh = 1'b1;
        send_vertex(v);
        // single-vertex mesh
        v = fresh_vertex();
        v.last_in_mesh = 1'b1;
        send_vertex(v);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_phase(27, 80, 1'b1);

        // stall results while vertices keep coming, then let the block drain
        hold_cycles <= HOLD_OFF_CYCLES;
        run_mesh(24, 30, 1'b0);
        vtx_valid <= 1'b0;
        wait_drained();

        run_phase(80, 27, 1'b0);
        run_phase(0, 0, 1'b1);

        vtx_valid <= 1'b0;
        wait_drained();
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("Covered %0d vertices in %0d meshes: %0d appended, %0d welded, %0d overflowed",
                 sb.vertices, sb.meshes, sb.appended, sb.matched, sb.overflowed);
        $display("Results checked: %0d, including a %0d-cycle result stall",
                 sb.checked, HOLD_OFF_CYCLES);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
